// ===== hw/rtl/pwbd_pkg.sv =====
// Shared types, constants and a helper function of the pulse-width byte decoder.
package pwbd_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int FAW        = $clog2(FIFO_DEPTH);
    localparam int FCW        = $clog2(FIFO_DEPTH + 1);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int          PAW           = 3;
    localparam logic        REG_THRESHOLD = 1'b0;
    localparam logic [15:0] THRESHOLD_RST = 16'h3000;

    localparam logic [7:0] CHAR_NL = 8'd10;

    typedef enum logic [1:0] {
        REQ_EDGE    = 2'd0,
        REQ_TIMEOUT = 2'd1,
        REQ_DRAIN   = 2'd2
    } t_req;

    typedef enum logic {
        BK_HIGH = 1'b0,
        BK_LOW  = 1'b1
    } t_back_state;

    typedef struct packed {
        logic       is_nl;
        logic [7:0] data;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        c = {4'd0, nib} + 8'd48;
        if (c >= 8'd58) begin
            c = c + 8'd7;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/pulse_width_byte_decoder_hex_out_unit.sv =====
// Top level of the pulse-width byte decoder with hex character output.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_stall       i_req_type, i_interval_count
//  output    out        o_out_valid / i_out_stall     o_char_code, o_last_of_run
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// An item is taken every cycle while the job queue has room; a drain item produces
// two characters, so a run of drains is held back by the single output register.
// A drain byte is read from the FIFO memory into a register at acceptance, and is
// pushed to the queue from there once the queue has room. Reset is synchronous and
// clears all control state; no memory clearing pass is needed. Output stalls back up
// through the two-entry job queue into o_in_stall.
module pulse_width_byte_decoder_hex_out_unit
    import pwbd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic [1:0]     i_req_type,
    input  logic [15:0]    i_interval_count,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_char_code,
    output logic           o_last_of_run,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [PAW-1:0] paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [15:0] r_threshold;
    logic        w_q_full;
    logic        w_q_push;
    t_job        w_push_job;
    logic        w_q_empty;
    logic        w_q_pop;
    t_job        w_head_job;

    assign pready = 1'b1;
    assign prdata = (paddr[PAW-1:2] == REG_THRESHOLD) ? {16'd0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[PAW-1:2] == REG_THRESHOLD) begin
            r_threshold <= pwdata[15:0];
        end
    end

    pwbd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_threshold      (r_threshold),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_interval_count (i_interval_count),
        .i_q_full         (w_q_full),
        .o_q_push         (w_q_push),
        .o_q_job          (w_push_job)
    );

    pwbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_job   (w_head_job)
    );

    pwbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .i_q_job       (w_head_job),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_char_code   (o_char_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hw/rtl/pwbd_front.sv =====
// Front end: accepts items, decodes pulse bits, keeps the byte FIFO and issues jobs.
module pwbd_front
    import pwbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_threshold,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_interval_count,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_job
);

    logic [7:0] byte_mem [FIFO_DEPTH];

    logic [7:0]     r_shift, n_shift;
    logic [2:0]     r_bit_cnt, n_bit_cnt;
    logic [FAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FCW-1:0] r_fill, n_fill;
    logic           r_line_pend, n_line_pend;
    logic           r_job_vld, n_job_vld;
    logic           r_job_nl, n_job_nl;
    logic [7:0]     r_rd_byte;

    logic           w_hold;
    logic           w_accept;
    logic           w_mem_we;
    logic           w_mem_re;
    logic           w_new_job;
    logic           w_new_nl;
    logic [FAW-1:0] w_wr_next;
    logic [FAW-1:0] w_rd_next;

    assign w_hold     = r_job_vld && i_q_full;
    assign o_in_stall = w_hold;
    assign w_accept   = i_in_valid && !w_hold;
    assign o_q_push   = r_job_vld && !i_q_full;
    assign o_q_job    = '{is_nl: r_job_nl, data: r_rd_byte};

    assign w_wr_next = (r_wr_ptr == FAW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_next = (r_rd_ptr == FAW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_shift     = r_shift;
        n_bit_cnt   = r_bit_cnt;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_line_pend = r_line_pend;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_new_job   = 1'b0;
        w_new_nl    = 1'b0;
        if (w_accept) begin
            case (t_req'(i_req_type))
                REQ_EDGE: begin
                    n_shift   = {r_shift[6:0], (i_interval_count >= i_threshold)};
                    n_bit_cnt = r_bit_cnt + 3'd1;
                    if (r_bit_cnt == 3'd7) begin
                        w_mem_we    = 1'b1;
                        n_wr_ptr    = w_wr_next;
                        n_line_pend = 1'b1;
                        // A full FIFO drops its oldest byte: the read side follows the write side.
                        if (r_fill == FCW'(FIFO_DEPTH)) begin
                            n_rd_ptr = w_wr_next;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
                REQ_TIMEOUT: begin
                    n_bit_cnt   = 3'd0;
                    n_line_pend = 1'b0;
                    w_new_job   = r_line_pend;
                    w_new_nl    = 1'b1;
                end
                REQ_DRAIN: begin
                    if (r_fill != '0) begin
                        w_mem_re  = 1'b1;
                        n_rd_ptr  = w_rd_next;
                        n_fill    = r_fill - 1'b1;
                        w_new_job = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        n_job_vld = w_hold || w_new_job;
        n_job_nl  = w_hold ? r_job_nl : w_new_nl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bit_cnt   <= '0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_line_pend <= 1'b0;
            r_job_vld   <= 1'b0;
            r_job_nl    <= 1'b0;
        end else begin
            r_shift     <= n_shift;
            r_bit_cnt   <= n_bit_cnt;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_line_pend <= n_line_pend;
            r_job_vld   <= n_job_vld;
            r_job_nl    <= n_job_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            byte_mem[r_wr_ptr] <= n_shift;
        end
        if (w_mem_re) begin
            r_rd_byte <= byte_mem[r_rd_ptr];
        end
    end

endmodule

// ===== hw/rtl/pwbd_queue.sv =====
// Short job queue between the front end and the character back end.
module pwbd_queue
    import pwbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job           r_entry [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_entry[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/pwbd_back.sv =====
// Back end: turns jobs into ASCII characters behind an output register.
module pwbd_back
    import pwbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_job       i_q_job,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_code,
    output logic       o_last_of_run
);

    t_back_state r_state, n_state;
    logic        r_out_vld, n_out_vld;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;
    logic        w_load;

    assign w_load = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_HIGH: begin
                if (w_load && !i_q_empty && !i_q_job.is_nl) begin
                    n_state = BK_LOW;
                end
            end
            BK_LOW: begin
                if (w_load) begin
                    n_state = BK_HIGH;
                end
            end
            default: begin
                n_state = BK_HIGH;
            end
        endcase
    end

    always_comb begin
        o_q_pop   = 1'b0;
        n_out_vld = r_out_vld && i_out_stall;
        n_char    = r_char;
        n_last    = r_last;
        if (w_load) begin
            case (r_state)
                BK_HIGH: begin
                    if (!i_q_empty) begin
                        n_out_vld = 1'b1;
                        o_q_pop   = i_q_job.is_nl;
                        n_char    = i_q_job.is_nl ? CHAR_NL : hex_char(i_q_job.data[7:4]);
                        n_last    = i_q_job.is_nl;
                    end
                end
                BK_LOW: begin
                    // The byte stays at the queue head until its low digit goes out.
                    n_out_vld = 1'b1;
                    o_q_pop   = 1'b1;
                    n_char    = hex_char(i_q_job.data[3:0]);
                    n_last    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_HIGH;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid   = r_out_vld;
    assign o_char_code   = r_char;
    assign o_last_of_run = r_last;

endmodule

// ===== test/pulse_width_byte_decoder_hex_out_unit_tb.sv =====
// Self-checking testbench for the pulse-width byte decoder with hex character output.
`timescale 1ns / 100ps

module pulse_width_byte_decoder_hex_out_unit_tb;
    import pwbd_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] ticks;
    } t_ir_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_hex_char;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    logic [1:0]     i_req_type;
    logic [15:0]    i_interval_count;
    logic           o_out_valid;
    logic           i_out_stall;
    logic [7:0]     o_char_code;
    logic           o_last_of_run;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;

    t_ir_item  ir_items[$];
    t_hex_char char_expect[$];
    int        errors = 0;
    int        items_taken = 0;
    int        chars_seen = 0;
    int        overruns = 0;
    int        idle_pct = 22;
    bit        in_taken = 0;
    bit        hold_armed = 0;
    bit        hold_done = 0;
    int        hold_left = 0;

    // Decoder state as the block should hold it.
    logic [15:0] thr_q;
    logic [7:0]  shift_q;
    logic [2:0]  bits_q;
    logic [7:0]  store_q [FIFO_DEPTH];
    logic [5:0]  wptr_q;
    logic [5:0]  rptr_q;
    logic [6:0]  fill_q;
    logic        line_q;

    pulse_width_byte_decoder_hex_out_unit uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'(n) + "0";
        end
        return 8'(n) - 8'd10 + "A";
    endfunction

    // Updates the decoder state for one accepted item and queues its characters.
    task automatic decode_item(input logic [1:0] kind, input logic [15:0] ticks);
        logic [7:0] b;
        case (kind)
            REQ_EDGE: begin
                shift_q = {shift_q[6:0], ticks >= thr_q};
                bits_q  = bits_q + 3'd1;
                if (bits_q == 3'd0) begin
                    store_q[wptr_q] = shift_q;
                    wptr_q = wptr_q + 6'd1;
                    if (fill_q == 7'(FIFO_DEPTH)) begin
                        rptr_q = wptr_q;
                        overruns++;
                    end else begin
                        fill_q = fill_q + 7'd1;
                    end
                    line_q = 1'b1;
                end
            end
            REQ_TIMEOUT: begin
                bits_q = 3'd0;
                if (line_q) begin
                    char_expect.push_back('{CHAR_NL, 1'b1});
                end
                line_q = 1'b0;
            end
            REQ_DRAIN: begin
                if (fill_q != 7'd0) begin
                    b = store_q[rptr_q];
                    rptr_q = rptr_q + 6'd1;
                    fill_q = fill_q - 7'd1;
                    char_expect.push_back('{nibble_ascii(b[7:4]), 1'b0});
                    char_expect.push_back('{nibble_ascii(b[3:0]), 1'b1});
                end
            end
            default: begin
            end
        endcase
    endtask

    // Input side: the next item goes out once the current one has been taken.
    always @(negedge i_clk) begin : in_driver
        t_ir_item it;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (ir_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                it = ir_items.pop_front();
                i_in_valid       <= 1'b1;
                i_req_type       <= it.kind;
                i_interval_count <= it.ticks;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side stall, with one long hold-off when the stimulus asks for it.
    always @(negedge i_clk) begin : out_driver
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_hex_char want;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            decode_item(i_req_type, i_interval_count);
            items_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            chars_seen++;
            if (char_expect.size() == 0) begin
                $display("%0t: char with none expected: got %h last %b", $time,
                         o_char_code, o_last_of_run);
                errors++;
            end else begin
                want = char_expect.pop_front();
                if (o_char_code !== want.ch) begin
                    $display("%0t: char_code expected %h got %h", $time, want.ch,
                             o_char_code);
                    errors++;
                end
                if (o_last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %b got %b", $time, want.last,
                             o_last_of_run);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic [15:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PAW'(REG_THRESHOLD) << 2;
        pwdata  <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        thr_q = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check();
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= PAW'(REG_THRESHOLD) << 2;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {16'd0, thr_q}) begin
            $display("%0t: bit_threshold readback expected %h got %h", $time,
                     {16'd0, thr_q}, got);
            errors++;
        end
    endtask

    task automatic add_item(input logic [1:0] kind, input logic [15:0] ticks);
        ir_items.push_back('{kind, ticks});
    endtask

    // Intervals cluster at the threshold so both sides of the compare are hit.
    function automatic logic [15:0] rand_ticks();
        int v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            v = int'(thr_q) + $urandom_range(0, 4) - 2;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            return 16'(v);
        end else if (sel < 33) begin
            return 16'h0000;
        end else if (sel < 41) begin
            return 16'hFFFF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly whole frames of bytes closed by a timeout and followed by drains,
    // with some stray items and cut-off frames mixed in.
    task automatic add_random(input int count);
        int added;
        int nbytes;
        int ndrains;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 99) < 80) begin
                nbytes = $urandom_range(1, 3);
                for (int i = 0; i < 8 * nbytes; i++) begin
                    add_item(REQ_EDGE, rand_ticks());
                end
                added += 8 * nbytes;
                if ($urandom_range(0, 99) < 85) begin
                    add_item(REQ_TIMEOUT, 16'($urandom_range(0, 65535)));
                    added++;
                end
                ndrains = $urandom_range(0, nbytes + 1);
                for (int i = 0; i < ndrains; i++) begin
                    add_item(REQ_DRAIN, 16'($urandom_range(0, 65535)));
                end
                added += ndrains;
            end else begin
                add_item(2'($urandom_range(0, 3)), rand_ticks());
                added++;
            end
        end
    endtask

    task automatic wait_quiet();
        while (ir_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (char_expect.size() != 0) @(posedge i_clk);
        // Edge items leave nothing to wait for, so give the pipeline time to settle.
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] thr, input int count);
        reg_write(thr);
        reg_check();
        add_random(count);
        wait_quiet();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_EDGE;
        i_interval_count = 16'd0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        thr_q = THRESHOLD_RST;
        shift_q = 8'd0;
        bits_q = 3'd0;
        wptr_q = 6'd0;
        rptr_q = 6'd0;
        fill_q = 7'd0;
        line_q = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        reg_check();
        // Empty FIFO, timeout with no line, and the unused code.
        add_item(REQ_DRAIN, 16'h0000);
        add_item(REQ_TIMEOUT, 16'hFFFF);
        add_item(REQ_UNUSED, 16'hFFFF);
        // One byte 0xAA, with intervals on both sides of the reset threshold.
        add_item(REQ_EDGE, 16'hFFFF);
        add_item(REQ_EDGE, 16'h0000);
        add_item(REQ_EDGE, THRESHOLD_RST);
        add_item(REQ_EDGE, THRESHOLD_RST - 16'd1);
        add_item(REQ_EDGE, 16'hFFFF);
        add_item(REQ_EDGE, 16'h0000);
        add_item(REQ_EDGE, THRESHOLD_RST);
        add_item(REQ_EDGE, 16'h0001);
        add_item(REQ_TIMEOUT, 16'h0000);
        add_item(REQ_TIMEOUT, 16'h0000);
        add_item(REQ_DRAIN, 16'hFFFF);
        add_item(REQ_DRAIN, 16'h0000);
        // A partial byte cut off by a timeout.
        add_item(REQ_EDGE, 16'hFFFF);
        add_item(REQ_EDGE, 16'h0000);
        add_item(REQ_EDGE, 16'hFFFF);
        add_item(REQ_TIMEOUT, 16'h0000);
        add_item(REQ_UNUSED, 16'h0000);
        wait_quiet();

        run_phase(16'h0000, 20);
        run_phase(16'hFFFF, 20);

        // The receiver holds off for a long stretch while items keep coming.
        reg_write(16'($urandom_range(0, 65535)));
        reg_check();
        hold_armed = 1'b1;
        add_random(40);
        wait_quiet();

        // Overfill the FIFO with no idling on either side, then drain a few of the
        // bytes that survived.
        idle_pct = 0;
        reg_write(THRESHOLD_RST);
        reg_check();
        add_item(REQ_TIMEOUT, 16'h0000);
        for (int i = 0; i < 8 * (FIFO_DEPTH + 2 - int'(fill_q)); i++) begin
            add_item(REQ_EDGE, rand_ticks());
        end
        add_item(REQ_TIMEOUT, 16'h0000);
        for (int i = 0; i < 8; i++) begin
            add_item(REQ_DRAIN, 16'($urandom_range(0, 65535)));
        end
        wait_quiet();
        idle_pct = 22;

        run_phase(16'($urandom_range(1, 65534)), 20);

        $display("Covered %0d items and %0d characters over six threshold settings,",
                 items_taken, chars_seen);
        $display("including %0d FIFO overruns and a long output hold-off.", overruns);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Timed out with %0d items and %0d characters outstanding.",
                 ir_items.size(), char_expect.size());
        $display("FAILURE");
        $finish;
    end

endmodule
